/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds on every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("%m: check failed");

// Implication: when ante holds, cons holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error("%m: check failed");

`endif

/* sv/itoa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package itoa_pkg;

  localparam int MaxDigitsDefault = 64;
  localparam int MaxCharsDefault  = 64;

  localparam int FlagZero   = 0;
  localparam int FlagSigned = 1;
  localparam int FlagPlus   = 2;
  localparam int FlagSpace  = 3;
  localparam int FlagLeft   = 4;
  localparam int FlagPrefix = 5;
  localparam int FlagUpper  = 6;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChUpX   = 8'h58;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_SETUP,
    ST_LPAD,
    ST_SIGN,
    ST_PFX0,
    ST_PFX1,
    ST_ZPAD,
    ST_PREC,
    ST_DIGIT,
    ST_RPAD,
    ST_BAD
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;
    logic div_start;
    logic setup;
    logic emit;
    logic [7:0] ch;
    logic use_digit;
    logic dec_pad;
    logic dec_prec;
    logic dec_digit;
  } cmd_t;

  // Status from datapath to controller.
  // out_full is set while the character on offer is the last one that fits.
  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic more_digits;
    logic pad_zero;
    logic pad_one;
    logic prec_zero;
    logic digit_zero;
    logic has_sign;
    logic [7:0] sign_ch;
    logic pfx8;
    logic pfx16;
    logic zeropad;
    logic left;
    logic upper;
    logic bad;
    logic out_full;
  } stat_t;

  // Digit value to ASCII character.
  function automatic logic [7:0] digit_char(input logic [5:0] d, input logic up);
    logic [7:0] c;
    if (d < 6'd10) c = ChZero + {2'b0, d};
    else if (up) c = 8'h41 + {2'b0, d} - 8'd10;
    else c = 8'h61 + {2'b0, d} - 8'd10;
    return c;
  endfunction

endpackage
`default_nettype wire

/* sv/itoa_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// Restoring radix divider, one quotient bit per cycle.
module itoa_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [5:0]  divisor,
  output logic             busy,
  output logic             done,
  output logic [63:0]      quotient,
  output logic [5:0]       remainder
);
  logic [63:0] q;
  logic [6:0]  r;
  logic [6:0]  cnt;
  logic [6:0]  trial;
  logic [6:0]  sh;

  assign sh    = {r[5:0], q[63]};
  assign trial = sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q    <= dividend;
        r    <= '0;
        cnt  <= 7'd64;
      end else if (busy) begin
        if (!trial[6]) begin
          r <= trial;
          q <= {q[62:0], 1'b1};
        end else begin
          r <= sh;
          q <= {q[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = q;
  assign remainder = r[5:0];
endmodule
`default_nettype wire

/* sv/itoa_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module itoa_dp #(
  parameter int MAX_DIGITS = itoa_pkg::MaxDigitsDefault,
  parameter int MAX_CHARS  = itoa_pkg::MaxCharsDefault
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire itoa_pkg::cmd_t  cmd,
  output itoa_pkg::stat_t      stat,
  input  wire logic [63:0]     value,
  input  wire logic [5:0]      radix,
  input  wire logic [5:0]      width,
  input  wire logic [5:0]      min_digits,
  input  wire logic [6:0]      flags,
  output logic [7:0]           out_char,
  output logic                 last_trunc
);
  localparam int DW = $clog2(MAX_DIGITS);
  localparam int CW = $clog2(MAX_CHARS + 1);

  logic [5:0]  digit_store [MAX_DIGITS];
  logic [63:0] work_value;
  logic [5:0]  rdx;
  logic [7:0]  size;
  logic [6:0]  prec;
  logic [6:0]  digit_count;
  logic [6:0]  pad_remaining;
  logic [6:0]  digit_idx;
  logic        lost;
  logic [6:0]  fl;
  logic [7:0]  sign_ch;
  logic        has_sign;
  logic [CW-1:0] emitted;
  logic        over;
  logic [1:0]  lead;
  logic [5:0]  rd_digit;

  logic        div_start_q;
  logic        div_busy, div_done;
  logic [63:0] quo;
  logic [5:0]  rem;
  logic [63:0] div_din;

  logic [6:0]  fl_in;
  logic        neg_in;
  logic [1:0]  lead_in;

  itoa_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(div_din),
    .divisor(rdx), .busy(div_busy), .done(div_done), .quotient(quo), .remainder(rem)
  );

  // Decode of the request on the input ports, used at the accepting edge.
  // lead counts the sign and prefix characters.
  always_comb begin
    neg_in = flags[itoa_pkg::FlagSigned] & value[63];
    fl_in  = flags;
    if (flags[itoa_pkg::FlagLeft]) fl_in[itoa_pkg::FlagZero] = 1'b0;
    lead_in = 2'd0;
    if (flags[itoa_pkg::FlagSigned] &
        (value[63] | flags[itoa_pkg::FlagPlus] | flags[itoa_pkg::FlagSpace]))
      lead_in = 2'd1;
    if (flags[itoa_pkg::FlagPrefix] && radix == 6'd16) lead_in = lead_in + 2'd2;
    else if (flags[itoa_pkg::FlagPrefix] && radix == 6'd8) lead_in = lead_in + 2'd1;
  end

  logic [7:0] sz_tot;
  logic [7:0] eff_prec;
  logic [6:0] pad_calc;
  logic [7:0] tot_len;
  always_comb begin
    eff_prec = ({1'b0, digit_count} > {1'b0, prec}) ? {1'b0, digit_count} : {1'b0, prec};
    sz_tot   = size - eff_prec;
    pad_calc = sz_tot[7] ? 7'd0 : sz_tot[6:0];
    tot_len  = {6'b0, lead} + eff_prec + {1'b0, pad_calc};
    // A new division continues from the quotient that has just come out.
    div_din  = div_done ? quo : work_value;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fl  <= fl_in;
      rdx <= radix;
      work_value <= neg_in ? (64'd0 - value) : value;
      has_sign <= flags[itoa_pkg::FlagSigned] &
                  (value[63] | flags[itoa_pkg::FlagPlus] | flags[itoa_pkg::FlagSpace]);
      sign_ch <= value[63] ? itoa_pkg::ChMinus :
                 flags[itoa_pkg::FlagPlus] ? itoa_pkg::ChPlus : itoa_pkg::ChSpace;
      lead <= lead_in;
      size <= {2'b0, width} - {6'b0, lead_in};
      prec <= {1'b0, min_digits};
      digit_count <= '0;
      lost <= 1'b0;
      emitted <= '0;
      over <= 1'b0;
    end
    if (div_done) begin
      work_value <= quo;
      if (digit_count < 7'(MAX_DIGITS)) begin
        digit_store[digit_count[DW-1:0]] <= rem;
        digit_count <= digit_count + 7'd1;
      end else begin
        lost <= 1'b1;
      end
    end
    if (cmd.setup) begin
      prec <= eff_prec[6:0] - digit_count;
      pad_remaining <= pad_calc;
      digit_idx <= digit_count - 7'd1;
      over <= (tot_len > 8'(MAX_CHARS));
    end
    if (cmd.dec_pad)   pad_remaining <= pad_remaining - 7'd1;
    if (cmd.dec_prec)  prec <= prec - 7'd1;
    if (cmd.dec_digit) digit_idx <= digit_idx - 7'd1;
    if (cmd.emit) emitted <= emitted + CW'(1);
    rd_digit <= digit_store[digit_idx[DW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) div_start_q <= 1'b0;
    else div_start_q <= cmd.div_start;
  end

  always_comb begin
    out_char = cmd.use_digit ? itoa_pkg::digit_char(rd_digit, fl[itoa_pkg::FlagUpper])
                             : cmd.ch;
    last_trunc = lost | over;
    stat.div_busy    = div_busy | div_start_q;
    stat.div_done    = div_done;
    stat.more_digits = (quo != 64'd0);
    stat.pad_zero    = (pad_remaining == 7'd0);
    stat.pad_one     = (pad_remaining == 7'd1);
    stat.prec_zero   = (prec == 7'd0);
    stat.digit_zero  = (digit_idx == 7'd0);
    stat.has_sign    = has_sign;
    stat.sign_ch     = sign_ch;
    stat.pfx8        = fl[itoa_pkg::FlagPrefix] && rdx == 6'd8;
    stat.pfx16       = fl[itoa_pkg::FlagPrefix] && rdx == 6'd16;
    stat.zeropad     = fl[itoa_pkg::FlagZero];
    stat.left        = fl[itoa_pkg::FlagLeft];
    stat.upper       = fl[itoa_pkg::FlagUpper];
    stat.bad         = (radix < 6'd2) || (radix > 6'd36);
    stat.out_full    = (emitted == CW'(MAX_CHARS - 1));
  end

  `ASSERT_CLK(a_emit_bound, clk, rst, emitted <= CW'(MAX_CHARS))
  `ASSERT_CLK(a_digit_bound, clk, rst, digit_count <= 7'(MAX_DIGITS))
  `ASSERT_NEXT(a_start_busy, clk, rst, cmd.div_start, div_busy)
endmodule
`default_nettype wire

/* sv/itoa_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module itoa_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic            out_stall,
  output logic                 out_valid,
  output logic                 is_last,
  output logic                 is_bad,
  output itoa_pkg::cmd_t       cmd,
  input  wire itoa_pkg::stat_t stat
);
  itoa_pkg::state_t state, state_next;
  logic fire;
  // Digit stage waits for the registered store read before the character is shown.
  logic rd_ok, rd_ok_next;

  assign fire = out_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itoa_pkg::ST_IDLE;
      rd_ok <= 1'b0;
    end else begin
      state <= state_next;
      rd_ok <= rd_ok_next;
    end
  end

  // Next state after the setup phase; setup always goes on to the left-pad phase.
  function automatic itoa_pkg::state_t after(input itoa_pkg::state_t s,
                                             input itoa_pkg::stat_t st);
    itoa_pkg::state_t n;
    n = s;
    if (n == itoa_pkg::ST_SETUP)
      n = (!st.zeropad && !st.left && !st.pad_zero) ? itoa_pkg::ST_LPAD : itoa_pkg::ST_LPAD;
    return n;
  endfunction

  logic lpad_on, sign_on, zpad_on, rpad_on;
  logic last_ch;
  always_comb begin
    lpad_on = !stat.zeropad && !stat.left && !stat.pad_zero;
    sign_on = stat.has_sign;
    zpad_on = stat.zeropad && !stat.pad_zero;
    rpad_on = stat.left && !stat.pad_zero;
  end

  always_comb begin
    state_next = state;
    rd_ok_next = 1'b0;
    unique case (state)
      itoa_pkg::ST_IDLE: begin
        if (in_valid) state_next = stat.bad ? itoa_pkg::ST_BAD : itoa_pkg::ST_DIV;
      end
      itoa_pkg::ST_DIV: begin
        if (stat.div_done && !stat.more_digits) state_next = itoa_pkg::ST_SETUP;
      end
      itoa_pkg::ST_SETUP: begin
        state_next = after(state, stat);
      end
      itoa_pkg::ST_LPAD: begin
        if (!lpad_on) state_next = itoa_pkg::ST_SIGN;
        else if (fire && last_ch) state_next = itoa_pkg::ST_IDLE;
      end
      itoa_pkg::ST_SIGN: begin
        if (!sign_on) state_next = itoa_pkg::ST_PFX0;
        else if (fire) state_next = last_ch ? itoa_pkg::ST_IDLE : itoa_pkg::ST_PFX0;
      end
      itoa_pkg::ST_PFX0: begin
        if (!(stat.pfx8 || stat.pfx16)) state_next = itoa_pkg::ST_ZPAD;
        else if (fire) state_next = last_ch ? itoa_pkg::ST_IDLE :
                                    stat.pfx16 ? itoa_pkg::ST_PFX1 : itoa_pkg::ST_ZPAD;
      end
      itoa_pkg::ST_PFX1: begin
        if (fire) state_next = last_ch ? itoa_pkg::ST_IDLE : itoa_pkg::ST_ZPAD;
      end
      itoa_pkg::ST_ZPAD: begin
        if (!zpad_on) state_next = itoa_pkg::ST_PREC;
        else if (fire && last_ch) state_next = itoa_pkg::ST_IDLE;
      end
      itoa_pkg::ST_PREC: begin
        if (stat.prec_zero) state_next = itoa_pkg::ST_DIGIT;
        else if (fire && last_ch) state_next = itoa_pkg::ST_IDLE;
      end
      itoa_pkg::ST_DIGIT: begin
        rd_ok_next = 1'b1;
        if (fire) begin
          rd_ok_next = 1'b0;
          if (last_ch) state_next = itoa_pkg::ST_IDLE;
          else if (stat.digit_zero) state_next = itoa_pkg::ST_RPAD;
        end
      end
      itoa_pkg::ST_RPAD: begin
        if (fire && last_ch) state_next = itoa_pkg::ST_IDLE;
      end
      itoa_pkg::ST_BAD: begin
        if (fire) state_next = itoa_pkg::ST_IDLE;
      end
      default: state_next = itoa_pkg::ST_IDLE;
    endcase
  end

  // Is the character currently offered the final one of the field?
  // Digits always follow the sign, prefix and leading padding, so only the final digit or final right pad ends a field,
  // or the character at the output limit.
  always_comb begin
    last_ch = 1'b0;
    if (state == itoa_pkg::ST_DIGIT && stat.digit_zero && !rpad_on) last_ch = 1'b1;
    if (state == itoa_pkg::ST_RPAD && stat.pad_one) last_ch = 1'b1;
    if (stat.out_full) last_ch = 1'b1;
  end

  always_comb begin
    cmd = '0;
    out_valid = 1'b0;
    in_stall = 1'b1;
    is_last = 1'b0;
    is_bad = 1'b0;
    unique case (state)
      itoa_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid & ~stat.bad;
      end
      itoa_pkg::ST_DIV: begin
        // The first division starts once the request is loaded; each further one
        // starts from the quotient of the previous one.
        cmd.div_start = (!stat.div_busy && !stat.div_done) ||
                        (stat.div_done && stat.more_digits);
      end
      itoa_pkg::ST_SETUP: cmd.setup = 1'b1;
      itoa_pkg::ST_LPAD: begin
        out_valid = lpad_on; cmd.ch = itoa_pkg::ChSpace; cmd.dec_pad = fire;
      end
      itoa_pkg::ST_SIGN: begin
        out_valid = sign_on; cmd.ch = stat.sign_ch;
      end
      itoa_pkg::ST_PFX0: begin
        out_valid = stat.pfx8 || stat.pfx16; cmd.ch = itoa_pkg::ChZero;
      end
      itoa_pkg::ST_PFX1: begin
        out_valid = 1'b1; cmd.ch = stat.upper ? itoa_pkg::ChUpX : itoa_pkg::ChLowX;
      end
      itoa_pkg::ST_ZPAD: begin
        out_valid = zpad_on; cmd.ch = itoa_pkg::ChZero; cmd.dec_pad = fire;
      end
      itoa_pkg::ST_PREC: begin
        out_valid = !stat.prec_zero; cmd.ch = itoa_pkg::ChZero; cmd.dec_prec = fire;
      end
      itoa_pkg::ST_DIGIT: begin
        out_valid = rd_ok; cmd.use_digit = 1'b1; cmd.dec_digit = fire;
      end
      itoa_pkg::ST_RPAD: begin
        out_valid = 1'b1; cmd.ch = itoa_pkg::ChSpace; cmd.dec_pad = fire;
      end
      itoa_pkg::ST_BAD: begin
        out_valid = 1'b1; is_bad = 1'b1; cmd.ch = 8'h00;
      end
      default: ;
    endcase
    is_last = is_bad | last_ch;
    cmd.emit = fire & ~is_bad;
  end

  `ASSERT_CLK(a_idle_quiet, clk, rst, !(state == itoa_pkg::ST_IDLE && out_valid))
  `ASSERT_NEXT(a_last_idle, clk, rst, fire && is_last, state == itoa_pkg::ST_IDLE)
endmodule
`default_nettype wire

/* sv/integer_to_ascii_formatter_top.sv */
// Throughput: one request at a time; the input stalls until the last character of the field is taken.
// A digit character is offered only after its registered digit store read.
// The bit-serial radix divider sets the time of the division phase, one division per digit.
// Reset (rst, synchronous, active high) returns the controller to idle, drops any request.
// The digit store needs no reset: every entry read was written for the same request.
`timescale 1ns / 1ps
`default_nettype none
module integer_to_ascii_formatter_top #(
  parameter int MAX_DIGITS = itoa_pkg::MaxDigitsDefault,
  parameter int MAX_CHARS  = itoa_pkg::MaxCharsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] value,
  input  wire logic [5:0]  radix,
  input  wire logic [5:0]  width,
  input  wire logic [5:0]  min_digits,
  input  wire logic [6:0]  flags,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_char,
  output logic             last,
  output logic             bad_radix,
  output logic             truncated
);
  itoa_pkg::cmd_t  cmd;
  itoa_pkg::stat_t stat;
  logic is_last, is_bad, trunc_flag;
  logic [7:0] ch;

  // The controller sequences division and character phases; the datapath
  // holds the request, the digit store and the counters.
  itoa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_stall(out_stall), .out_valid(out_valid), .is_last(is_last),
    .is_bad(is_bad), .cmd(cmd), .stat(stat)
  );

  itoa_dp #(.MAX_DIGITS(MAX_DIGITS), .MAX_CHARS(MAX_CHARS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .value(value), .radix(radix),
    .width(width), .min_digits(min_digits), .flags(flags), .out_char(ch),
    .last_trunc(trunc_flag)
  );

  // A bad radix gives a single NUL character flagged as an error.
  assign out_char  = is_bad ? 8'h00 : ch;
  assign last      = is_last;
  assign bad_radix = is_bad;
  // Truncation shows on the final character only, when characters or digits were cut.
  assign truncated = is_last & ~is_bad & trunc_flag;
endmodule
`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 1ps
module testbench;

  // Flag masks built from the bit positions that the package defines.
  localparam logic [6:0] F_ZERO   = 7'(1) << itoa_pkg::FlagZero;
  localparam logic [6:0] F_SIGNED = 7'(1) << itoa_pkg::FlagSigned;
  localparam logic [6:0] F_PLUS   = 7'(1) << itoa_pkg::FlagPlus;
  localparam logic [6:0] F_SPACE  = 7'(1) << itoa_pkg::FlagSpace;
  localparam logic [6:0] F_LEFT   = 7'(1) << itoa_pkg::FlagLeft;
  localparam logic [6:0] F_PREFIX = 7'(1) << itoa_pkg::FlagPrefix;
  localparam logic [6:0] F_UPPER  = 7'(1) << itoa_pkg::FlagUpper;

  localparam int FIELD_LIMIT = 64;     // characters kept per conversion
  localparam int DIGIT_LIMIT = 64;     // digits kept per conversion
  localparam int CYCLE_LIMIT = 20000000;
  localparam int HOLD_CYCLES = 6000;   // long receiver hold-off, longer than one conversion

  typedef struct {
    logic [63:0] val;
    logic [5:0]  base;
    logic [5:0]  fwidth;
    logic [5:0]  mindig;
    logic [6:0]  flg;
  } conv_req_t;

  typedef struct {
    logic [7:0] ch;
    logic       fin;
    logic       bad;
    logic       trunc;
  } field_char_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] value = '0;
  logic [5:0]  radix = '0;
  logic [5:0]  width = '0;
  logic [5:0]  min_digits = '0;
  logic [6:0]  flags = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_char;
  logic        last;
  logic        bad_radix;
  logic        truncated;

  conv_req_t   pending_reqs[$];
  field_char_t expected_chars[$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        hold_go = 1'b0;
  int          hold_left = 0;
  int          mismatches = 0;
  int          cycles = 0;

  integer_to_ascii_formatter_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .value(value), .radix(radix), .width(width), .min_digits(min_digits), .flags(flags),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_char(out_char), .last(last), .bad_radix(bad_radix), .truncated(truncated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Works out the full formatted field for one request and appends its characters to the
  // queue of expected characters. Padding order follows printf: spaces, sign, prefix,
  // zero padding, precision zeros, digits, trailing spaces.
  task automatic format_field(input conv_req_t rq);
    logic [7:0]  field[$];
    logic [5:0]  dig[DIGIT_LIMIT];
    logic [63:0] mag;
    logic [7:0]  sign_ch;
    logic [5:0]  d;
    logic        zpad, lft, lost;
    int          room, prec, ndig, pad, i, kept;
    field_char_t fc;
    zpad = rq.flg[itoa_pkg::FlagZero] && !rq.flg[itoa_pkg::FlagLeft];
    lft = rq.flg[itoa_pkg::FlagLeft];
    if (rq.base < 2 || rq.base > 36) begin
      // A bad radix yields a single flagged result with a null character.
      fc = '{ch: 8'h00, fin: 1'b1, bad: 1'b1, trunc: 1'b0};
      expected_chars.push_back(fc);
      return;
    end
    mag = rq.val;
    room = rq.fwidth;
    prec = rq.mindig;
    sign_ch = 8'h00;
    if (rq.flg[itoa_pkg::FlagSigned]) begin
      if (mag[63]) begin
        sign_ch = "-";
        mag = -mag;
      end else if (rq.flg[itoa_pkg::FlagPlus]) begin
        sign_ch = "+";
      end else if (rq.flg[itoa_pkg::FlagSpace]) begin
        sign_ch = " ";
      end
      if (sign_ch != 8'h00) room--;
    end
    if (rq.flg[itoa_pkg::FlagPrefix]) begin
      if (rq.base == 16) room -= 2;
      else if (rq.base == 8) room--;
    end
    ndig = 0;
    lost = 1'b0;
    do begin
      d = 6'(mag % 64'(rq.base));
      mag = mag / 64'(rq.base);
      if (ndig < DIGIT_LIMIT) begin
        dig[ndig] = d;
        ndig++;
      end else begin
        lost = 1'b1;
      end
    end while (mag != 0);
    if (ndig > prec) prec = ndig;
    room -= prec;
    pad = (room > 0) ? room : 0;
    if (!zpad && !lft) repeat (pad) field.push_back(" ");
    if (sign_ch != 8'h00) field.push_back(sign_ch);
    if (rq.flg[itoa_pkg::FlagPrefix]) begin
      if (rq.base == 8) begin
        field.push_back("0");
      end else if (rq.base == 16) begin
        field.push_back("0");
        field.push_back(rq.flg[itoa_pkg::FlagUpper] ? "X" : "x");
      end
    end
    if (zpad) repeat (pad) field.push_back("0");
    repeat (prec - ndig) field.push_back("0");
    for (i = ndig - 1; i >= 0; i--) begin
      if (dig[i] < 10) field.push_back(8'h30 + 8'(dig[i]));
      else if (rq.flg[itoa_pkg::FlagUpper]) field.push_back(8'h41 + 8'(dig[i]) - 8'd10);
      else field.push_back(8'h61 + 8'(dig[i]) - 8'd10);
    end
    if (lft) repeat (pad) field.push_back(" ");
    kept = (field.size() > FIELD_LIMIT) ? FIELD_LIMIT : field.size();
    for (i = 0; i < kept; i++) begin
      fc.ch = field[i];
      fc.fin = (i == kept - 1);
      fc.bad = 1'b0;
      fc.trunc = (i == kept - 1) && (field.size() > FIELD_LIMIT || lost);
      expected_chars.push_back(fc);
    end
  endtask

  // Random request. Most values are short so that the bit-serial divider does not
  // dominate the run time; a share are full 64-bit values and small negatives.
  function automatic conv_req_t random_request();
    conv_req_t rq;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) rq.val = 64'($urandom_range(0, 999));
    else if (sel < 60) rq.val = 64'($urandom);
    else if (sel < 75) rq.val = -64'($urandom_range(1, 100000));
    else rq.val = {$urandom, $urandom};
    sel = $urandom_range(0, 99);
    if (sel < 6) rq.base = 6'($urandom_range(0, 1));
    else if (sel < 10) rq.base = 6'($urandom_range(37, 63));
    else if (sel < 30) rq.base = 6'd16;
    else if (sel < 45) rq.base = 6'd10;
    else if (sel < 55) rq.base = 6'd8;
    else rq.base = 6'($urandom_range(2, 36));
    rq.fwidth = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(40, 63))
                                            : 6'($urandom_range(0, 20));
    rq.mindig = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(40, 63))
                                            : 6'($urandom_range(0, 12));
    rq.flg = 7'($urandom);
    return rq;
  endfunction

  // Request driver: a request is accepted when valid is high and stall is low at an edge.
  // The accepted request is predicted at that edge from the values it saw on the ports.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        format_field('{val: value, base: radix, fwidth: width, mindig: min_digits, flg: flags});
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          value      <= pending_reqs[0].val;
          radix      <= pending_reqs[0].base;
          width      <= pending_reqs[0].fwidth;
          min_digits <= pending_reqs[0].mindig;
          flags      <= pending_reqs[0].flg;
          void'(pending_reqs.pop_front());
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off counter, kept in its own process and started by the stimulus.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver stall: forced high during a hold-off, random otherwise.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (hold_left > 1) || ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Result monitor: each accepted character is compared with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected character %h last=%b bad=%b trunc=%b",
                   out_char, last, bad_radix, truncated);
      end else begin
        if (out_char !== expected_chars[0].ch || last !== expected_chars[0].fin ||
            bad_radix !== expected_chars[0].bad || truncated !== expected_chars[0].trunc) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Mismatch: expected ch=%h last=%b bad=%b trunc=%b, ",
                      "got ch=%h last=%b bad=%b trunc=%b"},
                     expected_chars[0].ch, expected_chars[0].fin, expected_chars[0].bad,
                     expected_chars[0].trunc, out_char, last, bad_radix, truncated);
        end
        void'(expected_chars.pop_front());
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Waits until every request has been sent and every expected character has arrived.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_chars.size() != 0);
  endtask

  task automatic add_req(input logic [63:0] v, input logic [5:0] b, input logic [5:0] w,
                         input logic [5:0] m, input logic [6:0] f);
    pending_reqs.push_back('{val: v, base: b, fwidth: w, mindig: m, flg: f});
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part, no idling: extremes and every special case of the conversion.
    add_req(64'd0, 6'd10, 6'd0, 6'd0, 7'd0);                      // zero with no precision
    add_req(64'd5, 6'd0, 6'd0, 6'd0, 7'd0);                       // bad radix, low end
    add_req(64'd5, 6'd1, 6'd3, 6'd0, 7'h7f);
    add_req(64'd5, 6'd37, 6'd0, 6'd0, 7'd0);                      // bad radix, high end
    add_req('1, 6'd63, 6'd63, 6'd63, 7'h7f);
    add_req('1, 6'd2, 6'd0, 6'd0, 7'd0);                          // 64 binary digits
    add_req('1, 6'd36, 6'd0, 6'd0, F_UPPER);                      // largest radix
    add_req(64'h8000_0000_0000_0000, 6'd10, 6'd0, 6'd0, F_SIGNED); // most negative value
    add_req(64'd42, 6'd10, 6'd8, 6'd0, F_SIGNED | F_PLUS);
    add_req(64'd42, 6'd10, 6'd8, 6'd0, F_SIGNED | F_SPACE);
    add_req(64'd42, 6'd10, 6'd8, 6'd0, F_SIGNED | F_PLUS | F_SPACE);
    add_req(64'd42, 6'd10, 6'd8, 6'd0, F_PLUS | F_SPACE);         // no sign when unsigned
    add_req(-64'd42, 6'd10, 6'd20, 6'd0, F_SIGNED | F_ZERO | F_LEFT);  // left cancels zero
    add_req(64'hbeef, 6'd16, 6'd20, 6'd0, F_ZERO | F_PREFIX);
    add_req(64'hbeef, 6'd16, 6'd20, 6'd6, F_PREFIX | F_UPPER);
    add_req(64'd0, 6'd8, 6'd0, 6'd0, F_PREFIX);                    // prefix on a zero value
    add_req(64'd0, 6'd16, 6'd4, 6'd0, F_PREFIX | F_LEFT);
    add_req(64'd99, 6'd10, 6'd0, 6'd0, F_PREFIX);                  // no prefix on radix 10
    add_req(-64'd1, 6'd16, 6'd63, 6'd63, F_SIGNED | F_PREFIX | F_ZERO);  // field cut at 64
    add_req('1, 6'd2, 6'd0, 6'd0, F_PREFIX | F_SIGNED | F_PLUS);
    add_req(64'h7fff_ffff_ffff_ffff, 6'd2, 6'd63, 6'd0, F_SIGNED | F_PLUS);  // sign plus 63 digits
    add_req(64'd7, 6'd10, 6'd0, 6'd63, F_SIGNED | F_PLUS);         // precision fills the field
    wait_drained();

    // Random requests across the idling phases.
    send_idle_pct = 64;
    repeat (100) pending_reqs.push_back(random_request());
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 64;
    repeat (100) pending_reqs.push_back(random_request());
    wait_drained();

    send_idle_pct = 21;
    recv_stall_pct = 21;
    repeat (100) pending_reqs.push_back(random_request());
    wait_drained();

    // Back-pressure: the receiver holds off for a long stretch while requests keep
    // coming, so the block backs up and stalls its own input.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (110) pending_reqs.push_back(random_request());
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    wait_drained();

    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
